// ----- src/eit_pkg.sv -----
// Package for the event interest table: item types, codes and event bits.
package eit_pkg;

  // Operation codes of the kind field
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_MODIFY = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_REPORT = 3'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  // Event bits
  localparam logic [31:0] EV_IN  = 32'h0000_0001;
  localparam logic [31:0] EV_OUT = 32'h0000_0004;
  localparam logic [31:0] EV_ERR = 32'h0000_0008;
  localparam logic [31:0] EV_HUP = 32'h0000_0010;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fd;
    logic        event_present;
    logic [31:0] watch_events;
    logic [63:0] user_data;
    logic        has_pipe;
    logic        pipe_has_data;
    logic        pipe_write_closed;
    logic        pipe_read_closed;
  } eit_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        ready_res;
    logic [31:0] ready_events;
    logic [63:0] ready_data;
  } eit_out_t;

  // Contents of one table cell
  typedef struct packed {
    logic [15:0] fd;
    logic [31:0] mask;
    logic [63:0] data;
  } eit_entry_t;

  // Per-cell update controls for the execute cycle
  typedef struct packed {
    logic load;    // append the new entry here
    logic modify;  // rewrite mask and data
    logic shift;   // take the neighbor's entry
  } eit_cell_ctl_t;

endpackage

// ----- src/eit_cell.sv -----
// One cell of the interest table: holds an entry, compares it, loads or rewrites it, shifts it down.
module eit_cell
  import eit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmp_en_i,
  input  logic [15:0]   cmp_fd_i,
  input  logic          occupied_i,
  input  eit_cell_ctl_t ctl_i,
  input  eit_entry_t    new_i,
  input  eit_entry_t    nbr_i,
  output eit_entry_t    entry_o,
  output logic          hit_o
);

  eit_entry_t entry_q, entry_d;
  logic       hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmp_en_i) begin
      hit_q <= occupied_i && (entry_q.fd == cmp_fd_i);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = new_i;
    end else if (ctl_i.modify) begin
      entry_d.mask = new_i.mask;
      entry_d.data = new_i.data;
    end else if (ctl_i.shift) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

// ----- src/event_interest_table_core.sv -----
// Event interest table: ordered table of watched descriptors with readiness report.
//
//  channel   direction  handshake                      payload
//  command   in         start / busy                   item_i   (eit_in_t)
//  result    out        result_valid_o, one-cycle      result_o (eit_out_t)
//
//  An item is handled thus: at the accept edge each cell compares its
//  descriptor with the item's; in the following cycle the row of cells
//  appends, rewrites or shifts down, and the result is registered.
//  The result strobe is high in the cycle after that, when busy is already
//  low again, so the next item can be accepted then; none is taken while busy.
//  Reset clears the fill count and control; cell contents need no reset.
//  The receiver cannot stall, so results never back up.
module event_interest_table_core
  import eit_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  eit_in_t  item_i,
  output logic     result_valid_o,
  output eit_out_t result_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int Lvl  = $clog2(TABLE_DEPTH);

  logic            busy_q;
  logic            accept;
  eit_in_t         cmd_q;
  logic [CntW-1:0] used_cnt_q, used_cnt_d;
  logic            res_valid_q;
  eit_out_t        res_q, res_d;

  eit_entry_t      entries [TABLE_DEPTH];
  eit_entry_t      nbrs    [TABLE_DEPTH];
  eit_cell_ctl_t   ctls    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hits, after, occupied, tail;

  eit_entry_t      new_entry;
  logic            found, full, add_ok, del_ok;
  logic [31:0]     sel_mask, raw_ev;
  logic [63:0]     sel_data;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
      used_cnt_q  <= '0;
    end else begin
      busy_q      <= accept;
      res_valid_q <= busy_q;
      if (busy_q) begin
        used_cnt_q <= used_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= item_i;
    end
    if (busy_q) begin
      res_q <= res_d;
    end
  end

  // Entry written on add or modify
  always_comb begin
    new_entry.fd   = cmd_q.fd;
    new_entry.mask = cmd_q.event_present ? cmd_q.watch_events : 32'd0;
    new_entry.data = cmd_q.event_present ? cmd_q.user_data : 64'd0;
  end

  assign found  = |hits;
  assign full   = (used_cnt_q == CntW'(TABLE_DEPTH));
  assign add_ok = busy_q && (cmd_q.kind == KIND_ADD) && !full && !found;
  assign del_ok = busy_q && (cmd_q.kind == KIND_DELETE) && found;

  // Mark the matching cell and every cell above it
  always_comb begin
    after = hits;
    for (int l = 0; l < Lvl; l++) begin
      after = after | (after << (1 << l));
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (CntW'(i) < used_cnt_q);
    assign tail[i]     = (CntW'(i) == used_cnt_q);

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nbrs[i] = entries[i];
    end else begin : g_mid
      assign nbrs[i] = entries[i+1];
    end

    always_comb begin
      ctls[i].load   = add_ok && tail[i];
      ctls[i].modify = busy_q && (cmd_q.kind == KIND_MODIFY) && cmd_q.event_present
                       && hits[i];
      ctls[i].shift  = del_ok && after[i];
    end

    eit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_en_i   (accept),
      .cmp_fd_i   (item_i.fd),
      .occupied_i (occupied[i]),
      .ctl_i      (ctls[i]),
      .new_i      (new_entry),
      .nbr_i      (nbrs[i]),
      .entry_o    (entries[i]),
      .hit_o      (hits[i])
    );
  end

  // At most one cell matches, so an AND-OR picks its contents
  always_comb begin
    sel_mask = '0;
    sel_data = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_mask = sel_mask | (hits[i] ? entries[i].mask : 32'd0);
      sel_data = sel_data | (hits[i] ? entries[i].data : 64'd0);
    end
  end

  always_comb begin
    raw_ev = '0;
    if (cmd_q.has_pipe) begin
      if (cmd_q.pipe_has_data)     raw_ev = raw_ev | EV_IN;
      if (cmd_q.pipe_write_closed) raw_ev = raw_ev | EV_IN | EV_HUP;
      if (cmd_q.pipe_read_closed)  raw_ev = raw_ev | EV_OUT | EV_ERR;
    end
    raw_ev = raw_ev | (sel_mask & (EV_ERR | EV_HUP));
    raw_ev = raw_ev & (sel_mask | EV_ERR | EV_HUP);
  end

  always_comb begin
    res_d      = '0;
    used_cnt_d = used_cnt_q;
    case (cmd_q.kind)
      KIND_ADD: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else if (found) begin
          res_d.status = ST_EXISTS;
        end else begin
          res_d.status = ST_OK;
          used_cnt_d   = used_cnt_q + CntW'(1);
        end
      end
      KIND_MODIFY: begin
        res_d.status = found ? ST_OK : ST_NOTFOUND;
      end
      KIND_DELETE: begin
        res_d.status = found ? ST_OK : ST_NOTFOUND;
        if (found) begin
          used_cnt_d = used_cnt_q - CntW'(1);
        end
      end
      KIND_REPORT: begin
        if (found) begin
          res_d.status       = ST_OK;
          res_d.ready_events = raw_ev;
          res_d.ready_res    = |raw_ev;
          res_d.ready_data   = sel_data;
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      default: begin
        res_d.status = ST_INVALID;
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("busy not raised after accept");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o && !busy)
    else $error("result strobe does not follow execute cycle");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $onehot0(hits))
    else $error("descriptor matches more than one cell");

  a_delete_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_ok |=> used_cnt_q == $past(used_cnt_q) - CntW'(1))
    else $error("delete did not shrink the table");
`endif

endmodule

// ----- dv/tb_event_interest_table_core.sv -----
// Testbench for event_interest_table_core: directed, fill/drain and random item checks.
`timescale 1ns / 1ps

module tb_event_interest_table_core;
  import eit_pkg::*;

  localparam int          DEPTH            = 256;
  localparam logic [2:0]  KIND_UNSUPPORTED = 3'd4;
  localparam logic [2:0]  KIND_LAST        = 3'd7;
  localparam logic [31:0] EV_ALL           = EV_IN | EV_OUT | EV_ERR | EV_HUP;
  localparam logic [63:0] DATA_ONES        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] FD_TOP           = 16'hFFFF;
  localparam int          RANDOM_ITEMS     = 750;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  eit_in_t  item_i;
  logic     result_valid_o;
  eit_out_t result_o;

  event_interest_table_core #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Predicted contents of the interest table
  logic [15:0] watch_fd   [DEPTH];
  logic [31:0] watch_mask [DEPTH];
  logic [63:0] watch_data [DEPTH];
  int          watch_count;

  eit_out_t awaited_replies[$];
  int       mismatch_count;
  bit       idle_enabled;
  int       ops_by_kind[8];
  int       peak_fill;
  int       full_rejects;
  int       ready_reports;

  function automatic int find_watch(logic [15:0] fd);
    for (int i = 0; i < watch_count; i++) begin
      if (watch_fd[i] == fd) return i;
    end
    return -1;
  endfunction

  // Apply one item to the predicted table and return the reply it should produce
  function automatic eit_out_t apply_table_op(eit_in_t op);
    eit_out_t    r;
    int          idx;
    logic [31:0] m;
    logic [31:0] raw;
    r   = '0;
    idx = find_watch(op.fd);
    case (op.kind)
      KIND_ADD: begin
        if (watch_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (idx >= 0) begin
          r.status = ST_EXISTS;
        end else begin
          watch_fd[watch_count]   = op.fd;
          watch_mask[watch_count] = op.event_present ? op.watch_events : '0;
          watch_data[watch_count] = op.event_present ? op.user_data : '0;
          watch_count++;
        end
      end
      KIND_MODIFY: begin
        if (idx < 0) begin
          r.status = ST_NOTFOUND;
        end else if (op.event_present) begin
          watch_mask[idx] = op.watch_events;
          watch_data[idx] = op.user_data;
        end
      end
      KIND_DELETE: begin
        if (idx < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // close the gap, keep insertion order
          for (int j = idx; j + 1 < watch_count; j++) begin
            watch_fd[j]   = watch_fd[j + 1];
            watch_mask[j] = watch_mask[j + 1];
            watch_data[j] = watch_data[j + 1];
          end
          watch_count--;
        end
      end
      KIND_REPORT: begin
        if (idx < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          m   = watch_mask[idx];
          raw = '0;
          if (op.has_pipe) begin
            if (op.pipe_has_data)     raw |= EV_IN;
            if (op.pipe_write_closed) raw |= EV_IN | EV_HUP;
            if (op.pipe_read_closed)  raw |= EV_OUT | EV_ERR;
          end
          raw |= m & (EV_ERR | EV_HUP);
          raw &= m | EV_ERR | EV_HUP;
          r.ready_events = raw;
          r.ready_res    = |raw;
          r.ready_data   = watch_data[idx];
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch in %0s at %0t: got %h, want %h", what, $time, got, want);
  endtask

  // Now and then, when idling is enabled, hold start low between items
  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Present one item, wait for acceptance and record the reply it should give
  task automatic issue_op(eit_in_t op);
    eit_out_t want;
    if (!start) start <= 1'b1;
    item_i <= op;
    do @(posedge clk_i); while (busy);
    want = apply_table_op(op);
    awaited_replies.push_back(want);
    ops_by_kind[op.kind]++;
    if (want.status == ST_FULL) full_rejects++;
    if (want.ready_res) ready_reports++;
    if (watch_count > peak_fill) peak_fill = watch_count;
    maybe_idle();
  endtask

  // Stop sending and hold off until every outstanding reply is in
  task automatic wait_replies();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_replies.size() != 0);
  endtask

  function automatic eit_in_t make_op(logic [2:0] kind, logic [15:0] fd, logic present,
                                      logic [31:0] events, logic [63:0] data,
                                      logic [3:0] pipe);
    eit_in_t op;
    op.kind              = kind;
    op.fd                = fd;
    op.event_present     = present;
    op.watch_events      = events;
    op.user_data         = data;
    op.has_pipe          = pipe[3];
    op.pipe_has_data     = pipe[2];
    op.pipe_write_closed = pipe[1];
    op.pipe_read_closed  = pipe[0];
    return op;
  endfunction

  // Mostly hit live descriptors, sometimes a small pool or anything
  function automatic logic [15:0] pick_fd();
    int r;
    r = $urandom_range(99);
    if (watch_count > 0 && r < 65) return watch_fd[$urandom_range(watch_count - 1)];
    if (r < 85) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  function automatic eit_in_t random_op(logic [2:0] kind);
    eit_in_t op;
    op.kind              = kind;
    op.fd                = pick_fd();
    op.event_present     = 1'($urandom_range(1));
    op.watch_events      = $urandom_range(1) ? 32'($urandom) : (32'($urandom) & EV_ALL);
    op.user_data         = {32'($urandom), 32'($urandom)};
    op.has_pipe          = $urandom_range(3) != 0;
    op.pipe_has_data     = 1'($urandom_range(1));
    op.pipe_write_closed = 1'($urandom_range(1));
    op.pipe_read_closed  = 1'($urandom_range(1));
    return op;
  endfunction

  function automatic logic [2:0] random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 28) return KIND_ADD;
    if (r < 43) return KIND_MODIFY;
    if (r < 65) return KIND_DELETE;
    if (r < 93) return KIND_REPORT;
    return 3'($urandom_range(KIND_UNSUPPORTED, KIND_LAST));
  endfunction

  always @(posedge clk_i) begin : check_replies
    eit_out_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch("reply with no item outstanding", 64'(result_o.status), '0);
      end else begin
        want = awaited_replies.pop_front();
        if (result_o.status !== want.status)
          flag_mismatch("status", 64'(result_o.status), 64'(want.status));
        if (result_o.ready_res !== want.ready_res)
          flag_mismatch("ready_res", 64'(result_o.ready_res), 64'(want.ready_res));
        if (result_o.ready_events !== want.ready_events)
          flag_mismatch("ready_events", 64'(result_o.ready_events), 64'(want.ready_events));
        if (result_o.ready_data !== want.ready_data)
          flag_mismatch("ready_data", result_o.ready_data, want.ready_data);
      end
    end
  end

  task automatic test_directed_cases();
    issue_op(make_op(KIND_REPORT, '0, 1'b0, '0, '0, 4'b1111));
    issue_op(make_op(KIND_MODIFY, '0, 1'b1, EV_ALL, DATA_ONES, 4'b0000));
    issue_op(make_op(KIND_DELETE, FD_TOP, 1'b0, '0, '0, 4'b0000));
    issue_op(make_op(KIND_ADD, '0, 1'b1, 32'hFFFF_FFFF, DATA_ONES, 4'b0000));
    // add without an event stores zero mask and data
    issue_op(make_op(KIND_ADD, FD_TOP, 1'b0, 32'hFFFF_FFFF, DATA_ONES, 4'b1111));
    issue_op(make_op(KIND_ADD, '0, 1'b1, EV_IN, 64'h1, 4'b0000));
    issue_op(make_op(KIND_REPORT, '0, 1'b0, '0, '0, 4'b1111));
    issue_op(make_op(KIND_REPORT, '0, 1'b0, '0, '0, 4'b0111));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1111));
    issue_op(make_op(KIND_MODIFY, FD_TOP, 1'b0, 32'hFFFF_FFFF, DATA_ONES, 4'b0000));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1111));
    issue_op(make_op(KIND_MODIFY, FD_TOP, 1'b1, EV_IN | EV_HUP,
                     64'h0123_4567_89AB_CDEF, 4'b0000));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1000));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1100));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1001));
    issue_op(make_op(KIND_ADD, 16'h1234, 1'b1, EV_OUT | EV_ERR,
                     64'h5555_AAAA_5555_AAAA, 4'b0000));
    // delete the first entry, later ones move down
    issue_op(make_op(KIND_DELETE, '0, 1'b0, '0, '0, 4'b0000));
    issue_op(make_op(KIND_REPORT, FD_TOP, 1'b0, '0, '0, 4'b1010));
    issue_op(make_op(KIND_REPORT, 16'h1234, 1'b0, '0, '0, 4'b1001));
    issue_op(make_op(KIND_DELETE, 16'h1234, 1'b0, '0, '0, 4'b0000));
    issue_op(make_op(KIND_REPORT, 16'h1234, 1'b0, '0, '0, 4'b1111));
    for (int k = KIND_UNSUPPORTED; k <= KIND_LAST; k++)
      issue_op(make_op(3'(k), FD_TOP, 1'b1, EV_ALL, DATA_ONES, 4'b1111));
    wait_replies();
  endtask

  task automatic test_fill_and_drain();
    eit_in_t op;
    while (watch_count < DEPTH) begin
      op = random_op($urandom_range(4) == 0 ? KIND_REPORT : KIND_ADD);
      if (op.kind == KIND_ADD && $urandom_range(3) != 0) op.fd = 16'($urandom);
      issue_op(op);
    end
    // full table rejects before the duplicate test
    issue_op(make_op(KIND_ADD, watch_fd[0], 1'b1, EV_ALL, DATA_ONES, 4'b0000));
    op = random_op(KIND_ADD);
    while (find_watch(op.fd) >= 0) op.fd = 16'($urandom);
    issue_op(op);
    repeat (20) issue_op(random_op($urandom_range(1) ? KIND_REPORT : KIND_MODIFY));
    issue_op(make_op(KIND_DELETE, watch_fd[DEPTH / 2], 1'b0, '0, '0, 4'b0000));
    issue_op(op);
    issue_op(random_op(KIND_ADD));
    while (watch_count > 0) begin
      op = random_op($urandom_range(3) == 0 ? KIND_REPORT : KIND_DELETE);
      op.fd = watch_fd[$urandom_range(watch_count - 1)];
      issue_op(op);
    end
    wait_replies();
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_enabled = !(n >= 250 && n < 400);
      if (n == 500) wait_replies();
      issue_op(random_op(random_kind()));
    end
    idle_enabled = 1'b1;
    wait_replies();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    item_i         = '0;
    watch_count    = 0;
    mismatch_count = 0;
    idle_enabled   = 1'b1;
    peak_fill      = 0;
    full_rejects   = 0;
    ready_reports  = 0;
    foreach (ops_by_kind[k]) ops_by_kind[k] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_random_mix();

    repeat (8) @(posedge clk_i);
    if (awaited_replies.size() != 0)
      flag_mismatch("replies still outstanding", 64'(awaited_replies.size()), '0);
    $display("items: add %0d, modify %0d, delete %0d, report %0d, unsupported %0d",
             ops_by_kind[KIND_ADD], ops_by_kind[KIND_MODIFY], ops_by_kind[KIND_DELETE],
             ops_by_kind[KIND_REPORT],
             ops_by_kind[4] + ops_by_kind[5] + ops_by_kind[6] + ops_by_kind[7]);
    $display("table peaked at %0d entries, %0d full rejects, %0d reports with events ready",
             peak_fill, full_rejects, ready_reports);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/eit_pkg.sv
src/eit_cell.sv
src/event_interest_table_core.sv
dv/tb_event_interest_table_core.sv
